### hw/rtl/tpdw_pkg.sv
// Shared types and constants for the textured pixel depth writer.
`default_nettype none

package tpdw_pkg;

	localparam int SCREEN_WIDTH  = 512;
	localparam int SCREEN_HEIGHT = 512;
	localparam int TEXTURE_SIDE  = 2048;

	localparam int DEPTH_ENTRIES = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int DEPTH_AW      = $clog2(DEPTH_ENTRIES);
	localparam int DEPTH_W       = 16;
	localparam int TEX_ENTRIES   = TEXTURE_SIDE * TEXTURE_SIDE;
	localparam int TEX_AW        = $clog2(TEX_ENTRIES);
	localparam int COORD_W       = 11;
	localparam int WRAP_W        = 6;
	localparam int PAL_W         = 7;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hffff;

	typedef enum logic [1:0] {
		CMD_TEX_WRITE = 2'd0,
		CMD_CLEAR     = 2'd1,
		CMD_FLAT      = 2'd2,
		CMD_TEXTURED  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic                en;
		logic [DEPTH_AW-1:0] addr;
		logic [DEPTH_W-1:0]  data;
	} depth_wr_t;

endpackage

`default_nettype wire

### hw/rtl/tpdw_depth_store.sv
// Depth store: RAM with post-reset clearing pass and same-edge write forwarding.
`default_nettype none

module tpdw_depth_store import tpdw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [DEPTH_AW-1:0] rd_addr,
	output logic [DEPTH_W-1:0]  rd_data,
	input  depth_wr_t           wr,
	output logic                busy
);

	logic [DEPTH_W-1:0]  mem_q [DEPTH_ENTRIES];
	logic [DEPTH_W-1:0]  rd_q;
	logic [DEPTH_W-1:0]  fwd_data_q;
	logic                fwd_q;
	logic                clearing_q;
	logic [DEPTH_AW-1:0] clr_cnt_q;

	logic                wen;
	logic [DEPTH_AW-1:0] waddr;
	logic [DEPTH_W-1:0]  wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			fwd_q      <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + DEPTH_AW'(1);
				if (clr_cnt_q == DEPTH_AW'(DEPTH_ENTRIES - 1))
					clearing_q <= 1'b0;
			end
			if (rd_en)
				fwd_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign wen   = clearing_q | wr.en;
	assign waddr = clearing_q ? clr_cnt_q : wr.addr;
	assign wdata = clearing_q ? DEPTH_MAX : wr.data;

	always_ff @(posedge clk) begin
		if (wen)
			mem_q[waddr] <= wdata;
		if (rd_en) begin
			rd_q       <= mem_q[rd_addr];
			fwd_data_q <= wr.data;
		end
	end

	// read and write of the same entry at one edge: take the new value
	assign rd_data = fwd_q ? fwd_data_q : rd_q;
	assign busy    = clearing_q;

endmodule

`default_nettype wire

### hw/rtl/textured_pixel_depth_writer_core.sv
// Textured pixel depth writer: three-stage pixel pipeline with depth and texture stores.
`default_nettype none

// Takes one transaction per clock while in_ready is high and returns one result per
// transaction, registered through stages 1, 2 and 3 in turn. Stage 1 registers the
// command and issues the depth and texture reads (texel writes also go in here),
// stage 2 does the depth and transparency tests and writes the depth store, and
// stage 3 holds the result. Back-to-back pixels at the same position are
// handled by forwarding the depth written at the read edge. After reset the
// depth store is swept to 0xFFFF, one entry per cycle, and in_ready stays low
// until the sweep is done.
module textured_pixel_depth_writer_core import tpdw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [8:0]  pos_x,
	input  logic [8:0]  pos_y,
	input  logic [15:0] depth,
	input  logic [15:0] tex_u,
	input  logic [15:0] tex_v,
	input  logic [15:0] shade,
	input  logic [1:0]  wrap_mode,
	input  logic [7:0]  base_x,
	input  logic [7:0]  base_y,
	input  logic [21:0] texel_address,
	input  logic [7:0]  texel_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  out_x,
	output logic [8:0]  out_y,
	output logic [15:0] pixel_value,
	output logic        write_enable
);

	function automatic logic [COORD_W-1:0] tex_coord(
		input logic [15:0] t,
		input logic        wrap,
		input logic [7:0]  base
	);
		logic [COORD_W-1:0] whole;
		logic [COORD_W-1:0] wrapped;
		whole   = t[4 +: COORD_W];
		wrapped = {base[COORD_W-5:0], 4'b0000} + COORD_W'(t[4 +: WRAP_W]);
		return wrap ? wrapped : whole;
	endfunction

	logic adv;
	logic accept;

	// input side
	logic [COORD_W-1:0] iu;
	logic [COORD_W-1:0] iv;
	logic [COORD_W-1:0] wcol;
	logic [COORD_W-1:0] wrow;
	logic [TEX_AW-1:0]  tex_addr_in;
	logic               tex_ok_in;
	logic               onscr_in;

	// stage 1
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [8:0]          x_s1;
	logic [8:0]          y_s1;
	logic [15:0]         z_s1;
	logic [15:0]         shade_s1;
	logic [TEX_AW-1:0]   tex_addr_s1;
	logic                tex_ok_s1;
	logic [7:0]          tex_data_s1;
	logic                onscr_s1;
	logic [DEPTH_AW-1:0] daddr_s1;

	// stage 2
	logic                valid_s2;
	cmd_t                cmd_s2;
	logic [8:0]          x_s2;
	logic [8:0]          y_s2;
	logic [15:0]         z_s2;
	logic [15:0]         shade_s2;
	logic                tex_ok_s2;
	logic [7:0]          tex_rd_s2;
	logic                onscr_s2;
	logic [DEPTH_AW-1:0] daddr_s2;

	logic [7:0]          texel;
	logic [DEPTH_W-1:0]  dep_rd;
	logic                z_pass;
	logic                we;
	logic [15:0]         value;
	depth_wr_t           dep_wr;
	logic                dep_busy;

	// stage 3
	logic                valid_s3;
	logic [8:0]          x_s3;
	logic [8:0]          y_s3;
	logic [15:0]         value_s3;
	logic                we_s3;

	logic [7:0]          tex_mem_q [TEX_ENTRIES];

	assign adv      = !valid_s3 || out_ready;
	assign in_ready = adv && !dep_busy;
	assign accept   = in_valid && in_ready;

	assign iu   = tex_coord(tex_u, wrap_mode[0], base_x);
	assign iv   = tex_coord(tex_v, wrap_mode[1], base_y);
	assign wcol = texel_address[COORD_W-1:0];
	assign wrow = texel_address[COORD_W +: COORD_W];

	always_comb begin
		if (cmd_t'(command) == CMD_TEX_WRITE) begin
			tex_addr_in = TEX_AW'(wrow) * TEX_AW'(TEXTURE_SIDE) + TEX_AW'(wcol);
			tex_ok_in   = (32'(wcol) < TEXTURE_SIDE) && (32'(wrow) < TEXTURE_SIDE);
		end else begin
			tex_addr_in = TEX_AW'(iv) * TEX_AW'(TEXTURE_SIDE) + TEX_AW'(iu);
			tex_ok_in   = (32'(iu) < TEXTURE_SIDE) && (32'(iv) < TEXTURE_SIDE);
		end
	end

	assign onscr_in = (32'(pos_x) < SCREEN_WIDTH) && (32'(pos_y) < SCREEN_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1      <= cmd_t'(command);
			x_s1        <= pos_x;
			y_s1        <= pos_y;
			z_s1        <= depth;
			shade_s1    <= shade;
			tex_addr_s1 <= tex_addr_in;
			tex_ok_s1   <= tex_ok_in;
			tex_data_s1 <= texel_data;
			onscr_s1    <= onscr_in;
			daddr_s1    <= DEPTH_AW'(pos_y) * DEPTH_AW'(SCREEN_WIDTH) + DEPTH_AW'(pos_x);

			cmd_s2      <= cmd_s1;
			x_s2        <= x_s1;
			y_s2        <= y_s1;
			z_s2        <= z_s1;
			shade_s2    <= shade_s1;
			tex_ok_s2   <= tex_ok_s1;
			onscr_s2    <= onscr_s1;
			daddr_s2    <= daddr_s1;

			x_s3        <= (cmd_s2 == CMD_TEX_WRITE) ? '0 : x_s2;
			y_s3        <= (cmd_s2 == CMD_TEX_WRITE) ? '0 : y_s2;
			value_s3    <= value;
			we_s3       <= we;
		end
	end

	// texture store: texel writes and reads both happen at the stage 1 edge
	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1 && cmd_s1 == CMD_TEX_WRITE && tex_ok_s1)
				tex_mem_q[tex_addr_s1] <= tex_data_s1;
			tex_rd_s2 <= tex_mem_q[tex_addr_s1];
		end
	end

	tpdw_depth_store u_depth (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (daddr_s1),
		.rd_data (dep_rd),
		.wr      (dep_wr),
		.busy    (dep_busy)
	);

	assign texel  = tex_ok_s2 ? tex_rd_s2 : 8'h00;
	assign z_pass = z_s2 <= dep_rd;

	always_comb begin
		we    = 1'b0;
		value = '0;
		unique case (cmd_s2)
			CMD_TEX_WRITE: begin
				we = 1'b0;
			end
			CMD_CLEAR: begin
				we = onscr_s2;
			end
			CMD_FLAT: begin
				we    = onscr_s2 && z_pass;
				value = shade_s2;
			end
			CMD_TEXTURED: begin
				we    = onscr_s2 && z_pass && (texel != 8'h00);
				value = {1'b0, shade_s2[PAL_W-1:0], texel};
			end
			default: begin
				we = 1'b0;
			end
		endcase
		if (!we)
			value = '0;
	end

	assign dep_wr.en   = adv && valid_s2 && we;
	assign dep_wr.addr = daddr_s2;
	assign dep_wr.data = (cmd_s2 == CMD_CLEAR) ? DEPTH_MAX : z_s2;

	assign out_valid    = valid_s3;
	assign out_x        = x_s3;
	assign out_y        = y_s3;
	assign pixel_value  = value_s3;
	assign write_enable = we_s3;

`ifndef SYNTHESIS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		dep_busy |-> !in_ready)
		else $error("transaction accepted during depth clearing pass");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && valid_s2) |=> (valid_s2 && $stable(z_s2) && $stable(daddr_s2)))
		else $error("stage 2 changed during output stall");

	a_blank_when_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |-> (pixel_value == 16'h0000))
		else $error("nonzero pixel value without write enable");
`endif

endmodule

`default_nettype wire
